/* hdl/usc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package usc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_WIDTH   = 16;
    localparam int LEN_WIDTH   = 16;
    localparam int CMP_W       = (COUNT_WIDTH + 1 > CAP_WIDTH + 1) ? COUNT_WIDTH + 1
                                                                   : CAP_WIDTH + 1;
    localparam logic [CMP_W-1:0] COUNT_MAX =
        CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = CAP_WIDTH'(256);

    localparam logic [7:0] BYTE_NUL        = 8'h00;
    localparam logic [7:0] BYTE_APOSTROPHE = 8'h27;
    localparam logic [7:0] QUOTE_B0        = 8'hE2;
    localparam logic [7:0] QUOTE_B1        = 8'h80;
    localparam logic [7:0] QUOTE_B2        = 8'h99;

    typedef enum logic [0:0] {
        REG_CAPACITY   = 1'b0,
        REG_PROSE_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0][7:0]        bytes;
        logic [2:0]             cnt;
        logic                   is_end;
        logic [LEN_WIDTH-1:0]   length;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_port_t;

    function automatic logic ascii_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'h80)
            n = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)
            n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            n = 3'd4;
        else
            n = 3'd1;
        return n;
    endfunction

endpackage

`default_nettype wire

/* hdl/usc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module usc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       in_byte,
    input  wire logic [usc_pkg::CAP_WIDTH-1:0]    capacity,
    input  wire logic                             prose_mode,
    output usc_pkg::q_port_t                      q_wr,
    input  wire logic                             q_full
);

    logic [usc_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic                            stopped_reg, stopped_next;
    logic [7:0]                      buf_reg [3];
    logic [7:0]                      buf_next [3];
    logic [2:0]                      len_reg, len_next;
    logic [1:0]                      held_reg, held_next;
    logic                            prev_letter_reg, prev_letter_next;
    logic                            pending_reg, pending_next;

    logic                            accept;
    logic                            letter;
    logic [4:1]                      fit;
    logic                            fit_len;
    logic                            fit_single;
    logic [2:0]                      lead_n;
    usc_pkg::q_entry_t               entry;
    logic                            stop;

    assign accept = in_valid && !q_full;
    assign in_stall = q_full;
    assign letter = usc_pkg::ascii_letter(in_byte);
    assign lead_n = usc_pkg::lead_length(in_byte);

    always_comb
    begin
        logic [usc_pkg::CMP_W-1:0] sum;
        for (int k = 1; k <= 4; k++)
        begin
            sum = usc_pkg::CMP_W'(count_reg) + usc_pkg::CMP_W'(k);
            fit[k] = (sum < usc_pkg::CMP_W'(capacity)) && (sum <= usc_pkg::COUNT_MAX);
        end
    end

    always_comb
    begin
        case (len_reg)
            3'd2:    fit_len = fit[2];
            3'd3:    fit_len = fit[3];
            3'd4:    fit_len = fit[4];
            default: fit_len = fit[1];
        endcase
    end

    always_comb
    begin
        entry        = '0;
        stop         = stopped_reg;
        pending_next = 1'b0;
        held_next    = held_reg;
        len_next     = len_reg;
        buf_next     = buf_reg;
        fit_single   = fit[1];

        // resolve a waiting apostrophe
        if (pending_reg)
        begin
            if (letter)
            begin
                if (fit[3])
                begin
                    entry.bytes[0] = usc_pkg::QUOTE_B0;
                    entry.bytes[1] = usc_pkg::QUOTE_B1;
                    entry.bytes[2] = usc_pkg::QUOTE_B2;
                    entry.cnt      = 3'd3;
                end
                else
                begin
                    stop = 1'b1;
                end
            end
            else if (fit[1])
            begin
                entry.bytes[0] = usc_pkg::BYTE_APOSTROPHE;
                entry.cnt      = 3'd1;
            end
            else
            begin
                stop = 1'b1;
            end
        end

        if (in_byte == usc_pkg::BYTE_NUL)
        begin
            entry.is_end = 1'b1;
            held_next    = 2'd0;
            len_next     = 3'd0;
        end
        else if (!stop)
        begin
            if (held_reg != 2'd0)
            begin
                if (({1'b0, held_reg} + 3'd1) >= len_reg)
                begin
                    if (fit_len)
                    begin
                        entry.bytes[0] = buf_reg[0];
                        entry.bytes[1] = (held_reg >= 2'd2) ? buf_reg[1] : in_byte;
                        entry.bytes[2] = (held_reg == 2'd3) ? buf_reg[2] : in_byte;
                        entry.bytes[3] = in_byte;
                        entry.cnt      = {1'b0, held_reg} + 3'd1;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                    held_next = 2'd0;
                    len_next  = 3'd0;
                end
                else
                begin
                    buf_next[held_reg] = in_byte;
                    held_next          = held_reg + 2'd1;
                end
            end
            else if (prose_mode && (in_byte == usc_pkg::BYTE_APOSTROPHE) && prev_letter_reg)
            begin
                pending_next = 1'b1;
            end
            else if (lead_n == 3'd1)
            begin
                case (entry.cnt)
                    3'd0:    fit_single = fit[1];
                    3'd1:    fit_single = fit[2];
                    default: fit_single = fit[4];
                endcase
                if (fit_single)
                begin
                    entry.bytes[entry.cnt[1:0]] = in_byte;
                    entry.cnt                   = entry.cnt + 3'd1;
                end
                else
                begin
                    stop = 1'b1;
                end
            end
            else
            begin
                buf_next[0] = in_byte;
                held_next   = 2'd1;
                len_next    = lead_n;
            end
        end

        entry.length = usc_pkg::LEN_WIDTH'(count_reg + usc_pkg::COUNT_WIDTH'(entry.cnt));

        if (in_byte == usc_pkg::BYTE_NUL)
        begin
            count_next   = '0;
            stopped_next = 1'b0;
        end
        else
        begin
            count_next   = count_reg + usc_pkg::COUNT_WIDTH'(entry.cnt);
            stopped_next = stop;
        end
        prev_letter_next = letter;
    end

    assign q_wr.valid = accept && ((entry.cnt != 3'd0) || entry.is_end);
    assign q_wr.entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            stopped_reg     <= 1'b0;
            len_reg         <= 3'd0;
            held_reg        <= 2'd0;
            prev_letter_reg <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else if (accept)
        begin
            count_reg       <= count_next;
            stopped_reg     <= stopped_next;
            len_reg         <= len_next;
            held_reg        <= held_next;
            prev_letter_reg <= prev_letter_next;
            pending_reg     <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/usc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module usc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire usc_pkg::q_port_t  q_wr,
    output logic                   q_full,
    output usc_pkg::q_port_t       q_rd,
    input  wire logic              q_pop
);

    usc_pkg::q_entry_t                 mem [usc_pkg::QUEUE_DEPTH];
    logic [usc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [usc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [usc_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_full     = (count_reg == usc_pkg::QCNT_W'(usc_pkg::QUEUE_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.entry = mem[rd_ptr_reg];
    assign do_push    = q_wr.valid && !q_full;
    assign do_pop     = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == usc_pkg::QPTR_W'(usc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + usc_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == usc_pkg::QPTR_W'(usc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + usc_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + usc_pkg::QCNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - usc_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wr.entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/usc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module usc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire usc_pkg::q_port_t               q_rd,
    output logic                                q_pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          out_byte,
    output logic                                is_end,
    output logic [usc_pkg::LEN_WIDTH-1:0]       written_length
);

    logic [2:0]                      idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    logic                            is_end_reg, is_end_next;
    logic [usc_pkg::LEN_WIDTH-1:0]   length_reg, length_next;
    logic                            load;
    logic                            is_data;
    logic                            last;

    assign load    = q_rd.valid && (!out_valid_reg || !out_stall);
    assign is_data = (idx_reg < q_rd.entry.cnt);
    assign last    = (is_data && !q_rd.entry.is_end && (idx_reg == q_rd.entry.cnt - 3'd1))
                   || (idx_reg == q_rd.entry.cnt);
    assign q_pop   = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        is_end_next    = is_end_reg;
        length_next    = length_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last ? 3'd0 : idx_reg + 3'd1;
            out_byte_next  = is_data ? q_rd.entry.bytes[idx_reg[1:0]] : usc_pkg::BYTE_NUL;
            is_end_next    = !is_data;
            length_next    = is_data ? '0 : q_rd.entry.length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        is_end_reg   <= is_end_next;
        length_reg   <= length_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign is_end         = is_end_reg;
    assign written_length = length_reg;

endmodule

`default_nettype wire

/* hdl/utf8_safe_truncating_copy.sv */
// An accepted input byte is written into the glyph queue, then into the output register.
// Throughput: one source byte per cycle while the 4-entry glyph queue has room;
// the output moves one result per cycle while out_stall is low, and a byte
// with more than one result holds it until all have moved (up to 4 results
// for a glyph or an expanded quote). Reset clears all string state and the
// queue; capacity resets to 256 and prose_mode to 0. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module utf8_safe_truncating_copy (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [usc_pkg::CAP_WIDTH-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     in_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          out_byte,
    output logic                                is_end,
    output logic [usc_pkg::LEN_WIDTH-1:0]       written_length
);

    logic [usc_pkg::CAP_WIDTH-1:0] capacity_reg, capacity_next;
    logic                          prose_mode_reg, prose_mode_next;
    usc_pkg::q_port_t              q_wr;
    usc_pkg::q_port_t              q_rd;
    logic                          q_full;
    logic                          q_pop;

    always_comb
    begin
        capacity_next   = capacity_reg;
        prose_mode_next = prose_mode_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                usc_pkg::REG_CAPACITY:   capacity_next   = cfg_data;
                usc_pkg::REG_PROSE_MODE: prose_mode_next = cfg_data[0];
                default:                 capacity_next   = capacity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= usc_pkg::CAPACITY_RESET;
            prose_mode_reg <= 1'b0;
        end
        else
        begin
            capacity_reg   <= capacity_next;
            prose_mode_reg <= prose_mode_next;
        end
    end

    usc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .capacity   (capacity_reg),
        .prose_mode (prose_mode_reg),
        .q_wr       (q_wr),
        .q_full     (q_full)
    );

    usc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    usc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_rd           (q_rd),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_end         (is_end),
        .written_length (written_length)
    );

`ifndef NO_ASSERTIONS
    a_len_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_end) |-> (written_length == '0))
        else $error("length field set on a data result");

    a_end_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_end) |-> (out_byte == usc_pkg::BYTE_NUL))
        else $error("end result carries a nonzero byte");

    a_len_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_end) |-> (written_length != '1))
        else $error("written length leaves no room for the NUL");
`endif

endmodule

`default_nettype wire
